[rtl/tth_pkg.sv]
// Shared types and constants for the timer task heap.
package tth_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RK_FIRED    = 3'd0,
    RK_ADDED    = 3'd1,
    RK_REJECTED = 3'd2,
    RK_REMOVED  = 3'd3,
    RK_TICK     = 3'd4
  } result_kind_t;

  localparam logic [31:0] WAIT_IDLE = 32'd1000;
  localparam logic [31:0] WAIT_MIN  = 32'd50;
  localparam logic [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [5:0]  COUNT_MAX = 6'd63;

  typedef struct packed {
    logic [47:0] due;
    logic [31:0] interval;
    logic [15:0] name;
    logic [31:0] tag;
    logic        rep;
    logic [31:0] age;
  } slot_t;

endpackage

[rtl/tth_req_if.sv]
// Request channel carrying one operation on the task table.
interface tth_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] name_key;
  logic [31:0] tag;
  logic        repeating;
  logic [47:0] due_time;
  logic [31:0] interval_ms;
  logic [47:0] now;

  modport source (output valid, action, name_key, tag, repeating, due_time,
                  interval_ms, now, input ready);
  modport sink (input valid, action, name_key, tag, repeating, due_time,
                interval_ms, now, output ready);
endinterface

[rtl/tth_rsp_if.sv]
// Response channel carrying one result of the task table.
interface tth_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] fired_name;
  logic [31:0] fired_tag;
  logic [47:0] fire_time;
  logic [5:0]  removed_count;
  logic [31:0] wait_ms;
  logic        last;

  modport source (output valid, result_kind, fired_name, fired_tag, fire_time,
                  removed_count, wait_ms, last, input ready);
  modport sink (input valid, result_kind, fired_name, fired_tag, fire_time,
                removed_count, wait_ms, last, output ready);
endinterface

[rtl/tth_ram.sv]
// Generic single-write, single-read RAM with a registered read.
module tth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/timer_task_heap.sv]
// Timer task table: adds, removes and fires timed tasks held in one RAM.
// The task records sit in a RAM with a single read port, so every operation
// walks the slots one per cycle. An add stops at the first free slot, a
// remove reads every slot, and a tick walks all slots once to find the
// earliest task and again after each task it fires. Results leave through
// an output register, and a new request is taken once the previous one has
// produced its final result.
module timer_task_heap #(
  parameter int CAPACITY      = 32,
  parameter int FIRE_LIMIT    = 32,
  parameter int LATE_LIMIT_MS = 1000
) (
  input logic        clk,
  input logic        rst,
  tth_req_if.sink    req,
  tth_rsp_if.source  rsp
);
  import tth_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int FIRE_W = $clog2(FIRE_LIMIT + 1);
  localparam int SW     = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_REM, S_REM_DONE, S_SCAN, S_DECIDE, S_FIRE
  } state_t;

  state_t             state;
  logic [CAPACITY-1:0] slot_valid;
  logic [31:0]        insert_counter;
  logic [CNT_W-1:0]   scan_i;
  logic               chk_vld;
  logic [IDX_W-1:0]   chk_idx;
  logic [15:0]        key;
  logic [31:0]        tag_r;
  logic               rep_r;
  logic [47:0]        due_r;
  logic [31:0]        ivl_r;
  logic [47:0]        now_r;
  logic [5:0]         rem_cnt;
  logic               found;
  slot_t              best;
  logic [IDX_W-1:0]   best_idx;
  logic [31:0]        best_old;
  logic [FIRE_W-1:0]  fired;
  logic [31:0]        wait_r;
  logic [47:0]        base;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  slot_t              ram_wdata;
  slot_t              rd;
  logic [SW-1:0]      rd_bits;
  logic               out_free;
  logic [31:0]        rd_old;
  logic [47:0]        lateness;
  logic [48:0]        next_due;
  logic [47:0]        ahead;

  assign rd       = slot_t'(rd_bits);
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rd_old   = insert_counter - rd.age;
  assign lateness = now_r - best.due;
  assign ahead    = best.due - now_r;
  assign next_due = {1'b0, base} + {17'd0, best.interval};

  tth_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_i[IDX_W-1:0]),
    .rdata (rd_bits)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = best;
    if (state == S_ADD && scan_i != CNT_W'(CAPACITY) &&
        !slot_valid[scan_i[IDX_W-1:0]] && out_free) begin
      ram_we    = 1'b1;
      ram_waddr = scan_i[IDX_W-1:0];
      ram_wdata = '{due: due_r, interval: (ivl_r == 32'd0) ? 32'd1 : ivl_r,
                    name: key, tag: tag_r, rep: rep_r, age: insert_counter};
    end else if (state == S_FIRE && out_free && best.rep) begin
      ram_we        = 1'b1;
      ram_wdata.due = next_due[48] ? TIME_MAX : next_due[47:0];
      ram_wdata.age = insert_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slot_valid     <= '0;
      insert_counter <= '0;
      rsp.valid      <= 1'b0;
      chk_vld        <= 1'b0;
      scan_i         <= '0;
      fired          <= '0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            key     <= req.name_key;
            tag_r   <= req.tag;
            rep_r   <= req.repeating;
            due_r   <= req.due_time;
            ivl_r   <= req.interval_ms;
            now_r   <= req.now;
            scan_i  <= '0;
            chk_vld <= 1'b0;
            rem_cnt <= '0;
            found   <= 1'b0;
            fired   <= '0;
            wait_r  <= WAIT_IDLE;
            unique case (action_t'(req.action))
              ACT_ADD:    state <= S_ADD;
              ACT_REMOVE: state <= S_REM;
              ACT_TICK:   state <= S_SCAN;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (scan_i == CNT_W'(CAPACITY)) begin
            if (out_free) begin
              rsp.valid         <= 1'b1;
              rsp.result_kind   <= RK_REJECTED;
              rsp.fired_name    <= '0;
              rsp.fired_tag     <= '0;
              rsp.fire_time     <= '0;
              rsp.removed_count <= '0;
              rsp.wait_ms       <= '0;
              rsp.last          <= 1'b1;
              state             <= S_IDLE;
            end
          end else if (!slot_valid[scan_i[IDX_W-1:0]]) begin
            if (out_free) begin
              slot_valid[scan_i[IDX_W-1:0]] <= 1'b1;
              insert_counter    <= insert_counter + 32'd1;
              rsp.valid         <= 1'b1;
              rsp.result_kind   <= RK_ADDED;
              rsp.fired_name    <= '0;
              rsp.fired_tag     <= '0;
              rsp.fire_time     <= '0;
              rsp.removed_count <= '0;
              rsp.wait_ms       <= '0;
              rsp.last          <= 1'b1;
              state             <= S_IDLE;
            end
          end else begin
            scan_i <= scan_i + CNT_W'(1);
          end
        end
        S_REM, S_SCAN: begin
          chk_vld <= (scan_i != CNT_W'(CAPACITY));
          chk_idx <= scan_i[IDX_W-1:0];
          if (scan_i != CNT_W'(CAPACITY)) begin
            scan_i <= scan_i + CNT_W'(1);
          end
          if (chk_vld && slot_valid[chk_idx]) begin
            if (state == S_REM) begin
              if (rd.name == key) begin
                slot_valid[chk_idx] <= 1'b0;
                if (rem_cnt != COUNT_MAX) begin
                  rem_cnt <= rem_cnt + 6'd1;
                end
              end
            end else if (!found || rd.due < best.due ||
                         (rd.due == best.due && rd_old > best_old)) begin
              found    <= 1'b1;
              best     <= rd;
              best_idx <= chk_idx;
              best_old <= rd_old;
            end
          end
          if (!chk_vld && scan_i == CNT_W'(CAPACITY)) begin
            state <= (state == S_REM) ? S_REM_DONE : S_DECIDE;
          end
        end
        S_REM_DONE: begin
          if (out_free) begin
            rsp.valid         <= 1'b1;
            rsp.result_kind   <= RK_REMOVED;
            rsp.fired_name    <= '0;
            rsp.fired_tag     <= '0;
            rsp.fire_time     <= '0;
            rsp.removed_count <= rem_cnt;
            rsp.wait_ms       <= '0;
            rsp.last          <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_DECIDE: begin
          if (!found || best.due > now_r || fired == FIRE_W'(FIRE_LIMIT)) begin
            if (out_free) begin
              rsp.valid         <= 1'b1;
              rsp.result_kind   <= RK_TICK;
              rsp.fired_name    <= '0;
              rsp.fired_tag     <= '0;
              rsp.fire_time     <= '0;
              rsp.removed_count <= '0;
              rsp.last          <= 1'b1;
              state             <= S_IDLE;
              if (!found) begin
                rsp.wait_ms <= wait_r;
              end else if (best.due > now_r) begin
                rsp.wait_ms <= (|ahead[47:32]) ? 32'hFFFF_FFFF : ahead[31:0];
              end else begin
                rsp.wait_ms <= '0;
              end
            end
          end else begin
            base  <= (lateness > 48'(LATE_LIMIT_MS)) ? now_r : best.due;
            state <= S_FIRE;
          end
        end
        S_FIRE: begin
          if (out_free) begin
            rsp.valid         <= 1'b1;
            rsp.result_kind   <= RK_FIRED;
            rsp.fired_name    <= best.name;
            rsp.fired_tag     <= best.tag;
            rsp.fire_time     <= base;
            rsp.removed_count <= '0;
            rsp.wait_ms       <= '0;
            rsp.last          <= 1'b0;
            if (best.rep) begin
              insert_counter <= insert_counter + 32'd1;
            end else begin
              slot_valid[best_idx] <= 1'b0;
            end
            fired   <= fired + FIRE_W'(1);
            wait_r  <= WAIT_MIN;
            found   <= 1'b0;
            scan_i  <= '0;
            chk_vld <= 1'b0;
            state   <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    fired <= FIRE_W'(FIRE_LIMIT))
    else $error("fire count exceeded its limit");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.result_kind == RK_FIRED |-> !rsp.last)
    else $error("fire result marked as final");

  a_oneshot_freed: assert property (@(posedge clk) disable iff (rst)
    state == S_FIRE && out_free && !best.rep |=> !slot_valid[$past(best_idx)])
    else $error("one-shot task not freed after firing");
`endif

endmodule
